@@ hdl/stbs_pkg.sv @@
// Shared types and constants of the sorted table binary search block.
package stbs_pkg;

  // Field widths of the stream and configuration beats.
  localparam int unsigned ENTRY_W = 32;
  localparam int unsigned IDX_W   = 10;
  localparam int unsigned SIZE_W  = 11;

  // Input tdata layout, lowest bits first, padded to whole bytes.
  localparam int unsigned IN_IDX_LSB  = 0;
  localparam int unsigned IN_VAL_LSB  = IN_IDX_LSB + IDX_W;
  localparam int unsigned IN_KEY_LSB  = IN_VAL_LSB + ENTRY_W;
  localparam int unsigned IN_USED_W   = IN_KEY_LSB + ENTRY_W;
  localparam int unsigned IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
  localparam int unsigned OUT_DATA_W  = 8;

  // Item kinds carried in tuser.
  localparam logic MODE_WRITE  = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  // Status of one probe step, handed from the step unit to the sequencer.
  typedef struct packed {
    logic hit;   // probed entry equals the key
    logic last;  // window has one entry left
  } step_stat_t;

endpackage

@@ hdl/sorted_table_binary_search.sv @@
// Top level of the sorted table binary search block: stream ports and probe sequencer.
//
// The block holds DEPTH signed 32-bit entries, which software writes in
// ascending order with write beats (tuser 0); a write gives no result, and a
// write to an index at or above DEPTH is dropped. A search beat (tuser 1)
// probes the first table_size entries, saturated at DEPTH, and returns one
// beat whose bit 0 is the found flag. A search makes at most ceil(log2(size))
// + 1 probes, one after another, since every probe uses the single read port
// of the entry store. An empty table is answered without a probe. The block
// takes no new beat while a search runs, but a finished result may wait in the
// output register while the next beat is accepted. The store is not cleared
// by reset; entries must be written before a search can reach them.
// table_size resets to zero and may be written only while the block is idle.
module sorted_table_binary_search #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write channel: table_size.
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [stbs_pkg::SIZE_W-1:0]       cfg_data_i,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // tdata: [9:0] entry_index, [41:10] entry_value, [73:42] search_key, rest zero.
  input  logic [stbs_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // tuser: [0] mode.
  input  logic [0:0]                        s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // tdata: [0] found, rest zero.
  output logic [stbs_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);
  import stbs_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_e;

  state_e                    state_q;
  logic [SIZE_W-1:0]         size_q;
  logic [CW-1:0]             lo_q;
  logic [CW-1:0]             span_q;
  logic [CW-1:0]             mid_q;
  logic signed [ENTRY_W-1:0] key_q;
  logic                      res_q;
  logic                      out_valid_q;
  logic                      out_found_q;

  logic                      in_beat;
  logic                      out_free;
  logic                      out_load;
  logic                      out_load_found;
  logic [IDX_W-1:0]          in_idx;
  logic signed [ENTRY_W-1:0] in_val;
  logic signed [ENTRY_W-1:0] in_key;
  logic [31:0]               idx_ext;
  logic [CW-1:0]             size_sat;
  logic [CW-1:0]             mid_first;
  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [AW-1:0]             mem_raddr;
  logic signed [ENTRY_W-1:0] mem_rdata;
  step_stat_t                stat;
  logic [CW-1:0]             lo_n;
  logic [CW-1:0]             span_n;
  logic [CW-1:0]             mid_n;

  // Handshakes and field unpacking.
  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = state_q == S_IDLE;
  assign in_beat         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign in_idx          = s_axis_tdata_i[IN_IDX_LSB +: IDX_W];
  assign in_val          = s_axis_tdata_i[IN_VAL_LSB +: ENTRY_W];
  assign in_key          = s_axis_tdata_i[IN_KEY_LSB +: ENTRY_W];
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(OUT_DATA_W-1){1'b0}}, out_found_q};

  // Table size saturated at the store depth, and the first probe point.
  always_comb begin
    if (32'(size_q) > 32'(DEPTH)) begin
      size_sat = CW'(DEPTH);
    end else begin
      size_sat = CW'(size_q);
    end
    mid_first = size_sat >> 1;
  end

  // Store ports: writes only from an accepted write beat inside the table.
  always_comb begin
    idx_ext   = {{(32-IDX_W){1'b0}}, in_idx};
    mem_we    = in_beat && (s_axis_tuser_i[0] == MODE_WRITE) && (idx_ext < 32'(DEPTH));
    mem_waddr = idx_ext[AW-1:0];
    mem_raddr = (state_q == S_PROBE) ? mid_n[AW-1:0] : mid_first[AW-1:0];
  end

  // A result enters the output register from the last probe or from the held result.
  always_comb begin
    out_load       = out_free && ((state_q == S_DONE) ||
                                  ((state_q == S_PROBE) && (stat.hit || stat.last)));
    out_load_found = (state_q == S_DONE) ? res_q : stat.hit;
  end

  stbs_table #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_val),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  stbs_step #(
    .CW (CW)
  ) u_step (
    .lo_i    (lo_q),
    .span_i  (span_q),
    .mid_i   (mid_q),
    .entry_i (mem_rdata),
    .key_i   (key_q),
    .stat_o  (stat),
    .lo_o    (lo_n),
    .span_o  (span_n),
    .mid_o   (mid_n)
  );

  // Probe sequencer, configuration register and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      size_q      <= '0;
      lo_q        <= '0;
      span_q      <= '0;
      mid_q       <= '0;
      key_q       <= '0;
      res_q       <= 1'b0;
      out_valid_q <= 1'b0;
      out_found_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_found_q <= out_load_found;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_beat && (s_axis_tuser_i[0] == MODE_SEARCH)) begin
            key_q  <= in_key;
            lo_q   <= '0;
            span_q <= size_sat;
            mid_q  <= mid_first;
            if (size_sat == '0) begin
              res_q   <= 1'b0;
              state_q <= S_DONE;
            end else begin
              state_q <= S_PROBE;
            end
          end
        end
        S_PROBE: begin
          if (stat.hit || stat.last) begin
            if (out_free) begin
              state_q <= S_IDLE;
            end else begin
              res_q   <= stat.hit;
              state_q <= S_DONE;
            end
          end else begin
            lo_q   <= lo_n;
            span_q <= span_n;
            mid_q  <= mid_n;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // The probe point always lies inside a non-empty window.
  a_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (span_q != '0) && (mid_q >= lo_q) && ((mid_q - lo_q) < span_q))
    else $error("probe point outside the search window");

  // The window never reaches past the saturated table size.
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> ({1'b0, lo_q} + {1'b0, span_q}) <= {1'b0, size_sat})
    else $error("search window beyond table size");

  // A result held in the sequencer after a probe waits only while the output register is occupied.
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE) && (span_q != '0) |-> out_valid_q)
    else $error("held result while output register is free");

endmodule

@@ hdl/stbs_table.sv @@
// Entry store: one write port and one read port with registered read data.
module stbs_table #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic                                clk_i,
  input  logic                                we_i,
  input  logic [AW-1:0]                       waddr_i,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] wdata_i,
  input  logic [AW-1:0]                       raddr_i,
  output logic signed [stbs_pkg::ENTRY_W-1:0] rdata_o
);
  import stbs_pkg::*;

  logic signed [ENTRY_W-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port, registered: data appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/stbs_step.sv @@
// Probe step unit: compares one entry with the key and narrows the search window.
module stbs_step #(
  parameter int unsigned CW = 11
) (
  input  logic [CW-1:0]                       lo_i,
  input  logic [CW-1:0]                       span_i,
  input  logic [CW-1:0]                       mid_i,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] entry_i,
  input  logic signed [stbs_pkg::ENTRY_W-1:0] key_i,
  output stbs_pkg::step_stat_t                stat_o,
  output logic [CW-1:0]                       lo_o,
  output logic [CW-1:0]                       span_o,
  output logic [CW-1:0]                       mid_o
);
  import stbs_pkg::*;

  logic          lt;
  logic [CW-1:0] span_lo;
  logic [CW-1:0] span_hi;

  // The window is [lo, lo + span) and mid sits at lo + span / 2.
  // Below the key the window keeps its upper part, above it the lower part.
  always_comb begin
    lt          = entry_i < key_i;
    stat_o.hit  = entry_i == key_i;
    stat_o.last = span_i == CW'(1);
    span_lo     = span_i >> 1;
    span_hi     = span_lo + CW'(span_i[0]);
    lo_o        = lt ? mid_i : lo_i;
    span_o      = lt ? span_hi : span_lo;
    mid_o       = lo_o + (span_o >> 1);
  end

endmodule

@@ dv/tb.sv @@
// Self-checking testbench for the sorted table binary search block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stbs_pkg::*;

  localparam int unsigned DEPTH  = 1024;
  localparam int unsigned SIZE_HI = (1 << SIZE_W) - 1;
  // Cycles to let the block go quiet: a full-table search plus margin.
  localparam int unsigned SETTLE = 16;
  localparam logic signed [ENTRY_W-1:0] S32_MIN = 32'sh8000_0000;
  localparam logic signed [ENTRY_W-1:0] S32_MAX = 32'sh7fff_ffff;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [SIZE_W-1:0]     cfg_data  = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_ready;
  logic [IN_DATA_W-1:0]  in_data   = '0;
  logic [0:0]            in_user   = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [OUT_DATA_W-1:0] out_data;

  // Mirror of the block state, updated from accepted beats only.
  logic signed [ENTRY_W-1:0] mirror_tbl [DEPTH];
  int unsigned               mirror_size = 0;
  bit                        found_q [$];
  int unsigned               fail_count = 0;

  // Stimulus-side copy of the table, used to aim search keys.
  logic signed [ENTRY_W-1:0] stim_tbl [DEPTH];
  bit                        stim_written [DEPTH];
  // Planned contents; an entry not yet written is sent once a search is about to read it.
  logic signed [ENTRY_W-1:0] plan_tbl [DEPTH];
  int unsigned               cur_size  = 0;
  int unsigned               idle_pct  = 0;
  int unsigned               stall_pct = 0;

  sorted_table_binary_search #(
    .DEPTH(DEPTH)
  ) u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_data_i      (cfg_data),
    .s_axis_tvalid_i (in_valid),
    .s_axis_tready_o (in_ready),
    .s_axis_tdata_i  (in_data),
    .s_axis_tuser_i  (in_user),
    .m_axis_tvalid_o (out_valid),
    .m_axis_tready_i (out_ready),
    .m_axis_tdata_o  (out_data)
  );

  // Free-running 100 MHz clock.
  initial begin
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #10_000_000;
    $display("tb NOT OK");
    $finish;
  end

  // Result sink stalls at random with the current stall rate.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  function automatic void note_fail(string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", what);
  endfunction

  // Walks the probe sequence over the mirrored table and returns the found flag.
  function automatic bit probe_hit(logic signed [ENTRY_W-1:0] key);
    int unsigned n, lo, hi, mid;
    logic signed [ENTRY_W-1:0] e;
    n = (mirror_size > DEPTH) ? DEPTH : mirror_size;
    if (n == 0) return 1'b0;
    lo  = 0;
    hi  = n;
    mid = lo + (hi - lo) / 2;
    while (mid != hi && mirror_tbl[mid] != key) begin
      e = mirror_tbl[mid];
      if ((hi - lo) / 2 == 0) hi = lo;
      if (e < key) lo = mid;
      if (key < e) hi = mid;
      mid = lo + (hi - lo) / 2;
    end
    if (mid >= DEPTH) return 1'b0;
    return (mirror_tbl[mid] == key);
  endfunction

  // Scoreboard: check result beats, then track config and input beats.
  always @(posedge clk) begin : scoreboard
    bit want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (found_q.size() == 0) begin
          note_fail($sformatf("result beat found=%0d with no search pending", out_data[0]));
        end else begin
          want = found_q.pop_front();
          if (out_data[0] !== want)
            note_fail($sformatf("found: expected %0d, got %0d", want, out_data[0]));
        end
      end
      if (cfg_valid && cfg_ready) mirror_size = 32'(cfg_data);
      if (in_valid && in_ready) begin
        if (in_user[0] == MODE_WRITE)
          mirror_tbl[in_data[IN_IDX_LSB +: IDX_W]] = in_data[IN_VAL_LSB +: ENTRY_W];
        else
          found_q = {found_q, probe_hit(in_data[IN_KEY_LSB +: ENTRY_W])};
      end
    end
  end

  // Sends one input beat after a random idle gap; valid stays high afterwards.
  task automatic send_item(logic mode, logic [IDX_W-1:0] idx,
                           logic signed [ENTRY_W-1:0] val, logic signed [ENTRY_W-1:0] key);
    logic [IN_DATA_W-1:0] d;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    d = '0;
    d[IN_IDX_LSB +: IDX_W]   = idx;
    d[IN_VAL_LSB +: ENTRY_W] = val;
    d[IN_KEY_LSB +: ENTRY_W] = key;
    in_valid <= 1'b1;
    in_data  <= d;
    in_user  <= mode;
    do @(posedge clk); while (!in_ready);
    if (mode == MODE_WRITE) begin
      stim_tbl[idx]     = val;
      stim_written[idx] = 1'b1;
    end
  endtask

  // Write beats carry a random search key, search beats random write fields.
  task automatic write_entry(int unsigned idx, logic signed [ENTRY_W-1:0] val);
    send_item(MODE_WRITE, IDX_W'(idx), val, $urandom);
  endtask

  // Follows the probe path of a key and first writes every entry on it that was
  // never written, taking the planned value.
  task automatic ensure_path(logic signed [ENTRY_W-1:0] key);
    int unsigned n, lo, hi, mid;
    logic signed [ENTRY_W-1:0] e;
    n = (cur_size > DEPTH) ? DEPTH : cur_size;
    if (n == 0) return;
    lo  = 0;
    hi  = n;
    mid = lo + (hi - lo) / 2;
    forever begin
      if (!stim_written[mid]) write_entry(mid, plan_tbl[mid]);
      e = stim_tbl[mid];
      if (e == key) break;
      if ((hi - lo) / 2 == 0) hi = lo;
      if (e < key) lo = mid;
      if (key < e) hi = mid;
      mid = lo + (hi - lo) / 2;
      if (mid == hi) break;
    end
  endtask

  task automatic search_key(logic signed [ENTRY_W-1:0] key);
    ensure_path(key);
    send_item(MODE_SEARCH, IDX_W'($urandom), $urandom, key);
  endtask

  // Stops the input stream, drains all results and lets the block go idle.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (found_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes table_size once the block is idle.
  task automatic set_size(int unsigned n);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= SIZE_W'(n);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cur_size = n;
    @(posedge clk);
  endtask

  // Plans entries 0..n-1 in ascending order, with duplicates now and then.
  function automatic void plan_sorted(int unsigned n);
    longint      acc;
    int unsigned step_max;
    bit          dense;
    dense    = ($urandom_range(3) == 0);
    step_max = dense ? 4 : 32'((64'd1 << 32) / (n + 1));
    acc      = dense ? longint'($signed($urandom)) : -(64'sd1 << 31) + $urandom_range(step_max);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(7) != 0) acc += $urandom_range(1, step_max);
      if (acc > S32_MAX) acc = S32_MAX;
      plan_tbl[i] = acc[ENTRY_W-1:0];
    end
  endfunction

  // Plans and writes entries 0..n-1 in ascending order.
  task automatic fill_sorted(int unsigned n);
    plan_sorted(n);
    for (int unsigned i = 0; i < n; i++) write_entry(i, plan_tbl[i]);
  endtask

  task automatic fill_unsorted(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      plan_tbl[i] = $urandom;
      write_entry(i, plan_tbl[i]);
    end
  endtask

  // Mostly keys present in the table or next to an entry, some random or extreme.
  function automatic logic signed [ENTRY_W-1:0] pick_key(int unsigned n);
    int unsigned used;
    int unsigned k;
    logic signed [ENTRY_W-1:0] e;
    used = (n > DEPTH) ? DEPTH : n;
    if (used == 0) return $urandom;
    k = $urandom_range(used - 1);
    e = stim_written[k] ? stim_tbl[k] : plan_tbl[k];
    case ($urandom_range(7)) inside
      [0:3]:   return e;
      4:       return e + 1;
      5:       return e - 1;
      6:       return $urandom;
      default: return $urandom_range(1) ? S32_MAX : S32_MIN;
    endcase
  endfunction

  // Searches right after reset see an empty table.
  task automatic test_empty_table();
    search_key(32'sd0);
    search_key(S32_MIN);
    search_key(S32_MAX);
    search_key(-32'sd1);
  endtask

  // Small hand-made tables: extremes, near misses, one entry, and an unsorted table.
  task automatic test_directed_table();
    write_entry(0, S32_MIN);
    write_entry(1, -32'sd7);
    write_entry(2, 32'sd0);
    write_entry(3, 32'sh55aa);
    write_entry(4, S32_MAX);
    write_entry(DEPTH - 1, -32'sd1);
    set_size(5);
    search_key(S32_MIN);
    search_key(-32'sd7);
    search_key(32'sd0);
    search_key(32'sh55aa);
    search_key(S32_MAX);
    search_key(-32'sd8);
    search_key(32'sd1);
    search_key(S32_MAX - 1);
    set_size(1);
    search_key(S32_MIN);
    search_key(32'sd0);
    // Break the ordering; the probe path decides what is found.
    write_entry(1, S32_MAX);
    set_size(5);
    search_key(32'sd0);
    search_key(-32'sd7);
    search_key(S32_MAX);
  endtask

  // Whole table in use, then sizes above DEPTH that must saturate.
  task automatic test_full_table();
    idle_pct  = 20;
    stall_pct = 20;
    plan_sorted(DEPTH);
    // Entries left over from earlier tests are brought in line with the plan.
    for (int unsigned i = 0; i < DEPTH; i++) begin
      if (stim_written[i]) write_entry(i, plan_tbl[i]);
    end
    set_size(DEPTH);
    repeat (40) search_key(pick_key(DEPTH));
    set_size(SIZE_HI);
    repeat (20) search_key(pick_key(DEPTH));
    set_size(DEPTH + 1);
    repeat (10) search_key(pick_key(DEPTH));
  endtask

  // Random tables and keys under each idling pattern.
  task automatic test_random_tables();
    int unsigned sel, n;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 77; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 77; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      repeat (3) begin
        sel = $urandom_range(9);
        if (sel == 0) begin
          n = 0;
        end else if (sel == 1) begin
          n = $urandom_range(DEPTH - 64, SIZE_HI);
        end else begin
          n = $urandom_range(1, 32);
          if ($urandom_range(4) == 0) fill_unsorted(n);
          else fill_sorted(n);
        end
        set_size(n);
        repeat (25) begin
          if ($urandom_range(9) == 0) write_entry($urandom_range(DEPTH - 1), $urandom);
          else search_key(pick_key(n));
        end
      end
    end
  endtask

  // Reset, run the tests in turn, drain and report.
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_table();
    test_directed_table();
    test_full_table();
    test_random_tables();
    settle();
    if (fail_count == 0 && found_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/stbs_pkg.sv
hdl/stbs_table.sv
hdl/stbs_step.sv
hdl/sorted_table_binary_search.sv
dv/tb.sv
